// ===== src/pdge_pkg.sv =====
// ---------------------------------------------------------------------------
// pdge_pkg: shared constants and G.711 segment encoders
// Packet length, configuration register indexes and reset values, and the
// mu-law / A-law companding functions used by the capture path.
// ---------------------------------------------------------------------------
package pdge_pkg;

    localparam int unsigned PACKET_SAMPLES = 160;
    localparam logic [7:0]  PACKET_LAST_COUNT = 8'(PACKET_SAMPLES - 1);

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DECIMATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALAW     = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd4096;

    localparam logic [13:0] ULAW_SEG_END [8] = '{
        14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
        14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
    };
    localparam logic [11:0] ALAW_SEG_END [8] = '{
        12'h01F, 12'h03F, 12'h07F, 12'h0FF,
        12'h1FF, 12'h3FF, 12'h7FF, 12'hFFF
    };
    localparam logic [13:0] ULAW_CLIP = 14'd8159;
    localparam logic [13:0] ULAW_BIAS = 14'h0021;
    localparam logic [3:0]  SEG_NONE  = 4'd8;

    function automatic logic [7:0] ulaw_encode(input logic signed [15:0] pcm);
        logic signed [13:0] v;
        logic [13:0]        mag;
        logic [7:0]         mask;
        logic [3:0]         seg;
        logic [3:0]         mant;
        logic               found;
        v = pcm[15:2];                  // floor divide by 4
        if (v[13]) begin
            mag  = (~v) + 14'd1;
            mask = 8'h7F;
        end else begin
            mag  = v;
            mask = 8'hFF;
        end
        if (mag > ULAW_CLIP) begin
            mag = ULAW_CLIP;
        end
        mag   = mag + ULAW_BIAS;
        seg   = SEG_NONE;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && mag <= ULAW_SEG_END[i]) begin
                seg   = 4'(i);
                found = 1'b1;
            end
        end
        mant = 4'(mag >> (seg + 4'd1));
        if (seg == SEG_NONE) begin
            return 8'h7F ^ mask;
        end
        return {1'b0, seg[2:0], mant} ^ mask;
    endfunction

    function automatic logic [7:0] alaw_encode(input logic signed [15:0] pcm);
        logic signed [12:0] v;
        logic [11:0]        mag;
        logic [7:0]         mask;
        logic [3:0]         seg;
        logic [3:0]         mant;
        logic               found;
        v = pcm[15:3];                  // floor divide by 8
        if (!v[12]) begin
            mag  = v[11:0];
            mask = 8'hD5;
        end else begin
            mag  = ~v[11:0];            // -v - 1
            mask = 8'h55;
        end
        seg   = SEG_NONE;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && mag <= ALAW_SEG_END[i]) begin
                seg   = 4'(i);
                found = 1'b1;
            end
        end
        if (seg < 4'd2) begin
            mant = 4'(mag >> 1);
        end else begin
            mant = 4'(mag >> seg);
        end
        if (seg == SEG_NONE) begin
            return 8'h7F ^ mask;
        end
        return {1'b0, seg[2:0], mant} ^ mask;
    endfunction

endpackage

// ===== src/pcm_decimate_gain_g711_encode_core.sv =====
// ---------------------------------------------------------------------------
// pcm_decimate_gain_g711_encode_core: microphone capture path
// Optional 2:1 pair averaging, Q4.12 gain with saturation, G.711 encoding
// and packet framing, taking one sample per clock unless the output stalls.
// ---------------------------------------------------------------------------
// Path: the transfer that completes a result loads stage A, then the output register.
// Throughput: one input transfer per cycle; two-stage pipeline (average and
//   packet count, then multiply/saturate/encode) that stalls only on output.
// Reset: synchronous active-low; clears pair and packet state, pipeline
//   valids, and loads decimation off, gain 4096 (unity), mu-law.
module pcm_decimate_gain_g711_encode_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdge_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pdge_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [15:0]                  i_sample,
    input  logic                                i_muted,
    input  logic                                i_block_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [15:0]                  o_narrowband,
    output logic [7:0]                          o_code,
    output logic                                o_packet_last
);

    logic        r_cfg_dec;
    logic [15:0] r_cfg_gain;
    logic        r_cfg_alaw;

    logic signed [15:0] r_held;
    logic               r_half_pair;
    logic [7:0]         r_pkt_count;

    logic               r_a_valid;
    logic signed [15:0] r_a_acc;
    logic               r_a_muted;
    logic               r_a_last;

    logic               r_out_valid;
    logic signed [15:0] r_out_nb;
    logic [7:0]         r_out_code;
    logic               r_out_last;

    logic               b_en;
    logic               a_en;
    logic               accept;
    logic               produce;
    logic signed [16:0] pair_sum;
    logic signed [15:0] n_acc;
    logic               n_half_pair;
    logic [7:0]         n_pkt_count;
    logic [7:0]         count_inc;
    logic               n_last;
    logic signed [15:0] enc_nb;
    logic [7:0]         enc_code;

    assign b_en       = !r_out_valid || !i_out_stall;
    assign a_en       = !r_a_valid || b_en;
    assign o_in_stall = !a_en;
    assign accept     = i_in_valid && a_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dec  <= 1'b0;
            r_cfg_gain <= pdge_pkg::GAIN_RESET;
            r_cfg_alaw <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdge_pkg::CFG_DECIMATE: r_cfg_dec  <= i_cfg_data[0];
                pdge_pkg::CFG_GAIN:     r_cfg_gain <= i_cfg_data;
                pdge_pkg::CFG_ALAW:     r_cfg_alaw <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pair averaging and packet counting for the incoming sample
    always_comb begin
        pair_sum    = 17'(r_held) + 17'(i_sample);
        n_half_pair = 1'b0;
        n_pkt_count = r_pkt_count;
        n_last      = 1'b0;
        produce     = 1'b1;
        n_acc       = i_sample;
        count_inc   = r_pkt_count + 8'd1;
        if (r_cfg_dec) begin
            if (!r_half_pair) begin
                produce = 1'b0;
                if (i_block_end) begin
                    n_pkt_count = 8'd0;     // odd leftover is dropped
                end else begin
                    n_half_pair = 1'b1;
                end
            end else begin
                // truncate toward zero
                n_acc = 16'((pair_sum + 17'(pair_sum[16])) >>> 1);
            end
        end
        if (produce) begin
            n_last      = i_block_end || (count_inc >= 8'(pdge_pkg::PACKET_SAMPLES));
            n_pkt_count = n_last ? 8'd0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_half_pair <= 1'b0;
            r_pkt_count <= '0;
        end else if (accept) begin
            if (r_cfg_dec && !r_half_pair) begin
                r_held <= i_sample;
            end
            r_half_pair <= n_half_pair;
            r_pkt_count <= n_pkt_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_en) begin
            r_a_valid <= accept && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en && accept && produce) begin
            r_a_acc   <= n_acc;
            r_a_muted <= i_muted;
            r_a_last  <= n_last;
        end
    end

    pdge_encode u_encode (
        .i_acc        (r_a_acc),
        .i_gain       (r_cfg_gain),
        .i_muted      (r_a_muted),
        .i_use_alaw   (r_cfg_alaw),
        .o_narrowband (enc_nb),
        .o_code       (enc_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && r_a_valid) begin
            r_out_nb   <= enc_nb;
            r_out_code <= enc_code;
            r_out_last <= r_a_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_narrowband  = r_out_nb;
    assign o_code        = r_out_code;
    assign o_packet_last = r_out_last;

    a_pass_clears_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !r_cfg_dec |=> !r_half_pair)
        else $error("half_pair left set after pass-through transfer");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt_count <= pdge_pkg::PACKET_LAST_COUNT)
        else $error("packet count beyond packet length");

    a_count_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && produce && r_pkt_count == pdge_pkg::PACKET_LAST_COUNT
        |=> r_pkt_count == 8'd0 && r_a_valid && r_a_last)
        else $error("full packet not closed");

    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !b_en |=> r_a_valid && $stable(r_a_acc) && $stable(r_a_last))
        else $error("pipeline stage lost data while output stalled");

    a_leftover_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_cfg_dec && !r_half_pair && i_block_end
        |=> !r_half_pair && r_pkt_count == 8'd0)
        else $error("odd leftover sample not discarded");

endmodule

// ===== src/pdge_encode.sv =====
// ---------------------------------------------------------------------------
// pdge_encode: gain, saturation and G.711 companding
// Multiplies the sample by the Q4.12 gain, truncates toward zero,
// saturates to 16 bits and encodes the (optionally muted) result.
// ---------------------------------------------------------------------------
module pdge_encode (
    input  logic signed [15:0] i_acc,
    input  logic        [15:0] i_gain,
    input  logic               i_muted,
    input  logic               i_use_alaw,
    output logic signed [15:0] o_narrowband,
    output logic        [7:0]  o_code
);

    logic signed [32:0] prod;
    logic signed [32:0] biased;
    logic signed [20:0] quot;
    logic signed [15:0] src;

    always_comb begin
        prod   = i_acc * $signed({1'b0, i_gain});
        // round toward zero on the divide by 4096
        biased = prod + (prod[32] ? 33'sd4095 : 33'sd0);
        quot   = biased[32:12];
        if (!quot[20] && (|quot[19:15])) begin
            o_narrowband = 16'sh7FFF;
        end else if (quot[20] && !(&quot[19:15])) begin
            o_narrowband = -16'sh8000;
        end else begin
            o_narrowband = quot[15:0];
        end
        src = i_muted ? 16'sd0 : o_narrowband;
        if (i_use_alaw) begin
            o_code = pdge_pkg::alaw_encode(src);
        end else begin
            o_code = pdge_pkg::ulaw_encode(src);
        end
    end

endmodule

// ===== tb/sv/g711_capture_monitor.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// g711_capture_monitor: prediction and result checking for the capture path
// Watches the register port and both channels. Each input transfer goes
// through a local model of pair averaging, Q4.12 gain with saturation,
// G.711 companding and packet framing. Each output transfer is checked
// against the oldest predicted sample.
// ---------------------------------------------------------------------------
module g711_capture_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdge_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pdge_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [15:0]                  i_sample,
    input  logic                                i_muted,
    input  logic                                i_block_end,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [15:0]                  i_narrowband,
    input  logic [7:0]                          i_code,
    input  logic                                i_packet_last,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);

    typedef struct packed {
        logic signed [15:0] narrowband;
        logic [7:0]         code;
        logic               packet_last;
    } t_coded_sample;

    t_coded_sample      coded_q[$];

    logic               decimate_on;
    logic [15:0]        gain_q412;
    logic               alaw_on;
    logic signed [15:0] pair_first;
    logic               pair_open;
    logic [7:0]         samples_in_packet;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // segment ends are (64 << seg) - 1 after the 0x21 bias
    function automatic logic [7:0] mulaw_byte(input int pcm);
        int         mag;
        int         seg;
        logic [7:0] flip;
        mag = pcm >>> 2;
        if (mag < 0) begin
            mag  = -mag;
            flip = 8'h7F;
        end else begin
            flip = 8'hFF;
        end
        if (mag > 8159) begin
            mag = 8159;
        end
        mag = mag + 33;
        seg = 0;
        while (seg < 8 && mag > ((64 << seg) - 1)) begin
            seg++;
        end
        if (seg == 8) begin
            return 8'h7F ^ flip;
        end
        return {1'b0, 3'(seg), 4'(mag >> (seg + 1))} ^ flip;
    endfunction

    // negative side uses one's complement magnitude; 4095 is the top of segment 7
    function automatic logic [7:0] alaw_byte(input int pcm);
        int         mag;
        int         seg;
        logic [7:0] flip;
        mag = pcm >>> 3;
        if (mag >= 0) begin
            flip = 8'hD5;
        end else begin
            flip = 8'h55;
            mag  = -mag - 1;
        end
        seg = 0;
        while (seg < 8 && mag > ((32 << seg) - 1)) begin
            seg++;
        end
        if (seg < 2) begin
            return {1'b0, 3'(seg), 4'(mag >> 1)} ^ flip;
        end
        return {1'b0, 3'(seg), 4'(mag >> seg)} ^ flip;
    endfunction

    task automatic encode_sample(input logic signed [15:0] pcm, input logic muted,
                                 input logic block_end);
        int            avg;
        longint        scaled;
        t_coded_sample res;
        if (decimate_on) begin
            if (!pair_open) begin
                // odd leftover at block end: dropped, packet restarts unmarked
                if (block_end) begin
                    samples_in_packet = '0;
                end else begin
                    pair_first = pcm;
                    pair_open  = 1'b1;
                end
                return;
            end
            avg = (int'(pair_first) + int'(pcm)) / 2;
        end else begin
            avg = pcm;
        end
        pair_open = 1'b0;

        scaled = (longint'(avg) * longint'(gain_q412)) / 4096;
        if (scaled > 32767) begin
            res.narrowband = 16'sh7FFF;
        end else if (scaled < -32768) begin
            res.narrowband = 16'sh8000;
        end else begin
            res.narrowband = 16'(scaled);
        end
        res.code = alaw_on ? alaw_byte(muted ? 0 : int'(res.narrowband))
                           : mulaw_byte(muted ? 0 : int'(res.narrowband));

        samples_in_packet = samples_in_packet + 8'd1;
        res.packet_last   = block_end ||
                            (samples_in_packet >= pdge_pkg::PACKET_SAMPLES);
        if (res.packet_last) begin
            samples_in_packet = '0;
        end
        coded_q.push_back(res);
    endtask

    task automatic compare_result();
        t_coded_sample want;
        if (coded_q.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("%0t: unpredicted result nb=%0d code=%02h last=%0b",
                         $realtime, i_narrowband, i_code, i_packet_last);
            end
            return;
        end
        want = coded_q.pop_front();
        if (i_narrowband !== want.narrowband || i_code !== want.code ||
            i_packet_last !== want.packet_last) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("%0t: exp nb=%0d code=%02h last=%0b got nb=%0d code=%02h last=%0b",
                         $realtime, want.narrowband, want.code, want.packet_last,
                         i_narrowband, i_code, i_packet_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            decimate_on       = 1'b0;
            gain_q412         = pdge_pkg::GAIN_RESET;
            alaw_on           = 1'b0;
            pair_first        = '0;
            pair_open         = 1'b0;
            samples_in_packet = '0;
            coded_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pdge_pkg::CFG_DECIMATE: decimate_on = i_cfg_data[0];
                    pdge_pkg::CFG_GAIN:     gain_q412   = i_cfg_data;
                    pdge_pkg::CFG_ALAW:     alaw_on     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                compare_result();
            end
            if (i_in_valid && !i_in_stall) begin
                encode_sample(i_sample, i_muted, i_block_end);
            end
        end
        o_outstanding = coded_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: capture path testbench
// Directed corner samples, then random sample streams under a range of
// gain, decimation and companding settings and handshake pressure. Results
// are checked by g711_capture_monitor.
// ---------------------------------------------------------------------------
module tb_top;

    localparam logic [pdge_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [pdge_pkg::CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [pdge_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic signed [15:0]                 i_sample = '0;
    logic                               i_muted = 1'b0;
    logic                               i_block_end = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic signed [15:0]                 o_narrowband;
    logic [7:0]                         o_code;
    logic                               o_packet_last;

    int mismatches;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int block_end_pct = 0;

    always #1 i_clk = ~i_clk;

    pcm_decimate_gain_g711_encode_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .i_muted       (i_muted),
        .i_block_end   (i_block_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_narrowband  (o_narrowband),
        .o_code        (o_code),
        .o_packet_last (o_packet_last)
    );

    g711_capture_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .i_muted       (i_muted),
        .i_block_end   (i_block_end),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_narrowband  (o_narrowband),
        .i_code        (o_code),
        .i_packet_last (o_packet_last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // stall is settled by the falling edge, so a transfer is known at the falling
    // edge ahead of the edge that takes it
    task automatic send_sample(input logic signed [15:0] pcm, input logic muted,
                               input logic block_end);
        logic taken;
        i_in_valid  <= 1'b1;
        i_sample    <= pcm;
        i_muted     <= muted;
        i_block_end <= block_end;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold off until every predicted sample is out, then let the pipe empty
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic decimate, input logic [15:0] gain,
                                input logic alaw);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pdge_pkg::CFG_DECIMATE;
        i_cfg_data  <= {15'd0, decimate};
        @(posedge i_clk);
        i_cfg_index <= pdge_pkg::CFG_GAIN;
        i_cfg_data  <= gain;
        @(posedge i_clk);
        i_cfg_index <= pdge_pkg::CFG_ALAW;
        i_cfg_data  <= {15'd0, alaw};
        @(posedge i_clk);
        // unmapped index, must be ignored
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // log-spread magnitudes so every companding segment gets traffic
    function automatic logic signed [15:0] pick_sample();
        int mag;
        mag = $urandom_range(1 << $urandom_range(1, 15));
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return -16'sd1;
                endcase
            end
            1, 2, 3, 4, 5: return $urandom_range(1) ? 16'(-mag) : 16'(mag);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(4700, 3500));
            2: return 16'($urandom_range(1024));
            default: return 16'hFFFF - 16'($urandom_range(255));
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: pass-through, unity gain, mu-law
        send_sample(16'sh7FFF, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh0000, 1'b0, 1'b0);
        send_sample(-16'sd1,   1'b0, 1'b0);
        send_sample(16'sd1,    1'b0, 1'b0);
        send_sample(16'sh8000, 1'b1, 1'b0);
        send_sample(16'sd129,  1'b0, 1'b1);

        // pairs at full gain, A-law: saturation both ways, rounding toward zero
        program_regs(1'b1, 16'hFFFF, 1'b1);
        send_sample(16'sh7FFF, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(-16'sd1,   1'b0, 1'b0);
        send_sample(16'sd0,    1'b0, 1'b0);
        send_sample(16'sd5,    1'b0, 1'b1);     // odd leftover, dropped
        send_sample(16'sd3,    1'b0, 1'b0);
        send_sample(-16'sd6,   1'b1, 1'b1);

        // half pair survives a gain change while decimation stays on
        send_sample(16'sd1000, 1'b0, 1'b0);
        program_regs(1'b1, 16'h0000, 1'b0);
        send_sample(16'sd2000, 1'b0, 1'b0);

        // half pair dropped when decimation goes off
        send_sample(16'sd777,  1'b0, 1'b0);
        program_regs(1'b0, pdge_pkg::GAIN_RESET, 1'b1);
        send_sample(-16'sd1,   1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b1);
        send_sample(16'sd8,    1'b0, 1'b0);

        for (int seg = 0; seg < 16; seg++) begin
            case (seg)
                0: program_regs(1'b0, pdge_pkg::GAIN_RESET, 1'b0);
                1: program_regs(1'b1, pdge_pkg::GAIN_RESET, 1'b1);
                2: program_regs(1'b0, 16'hFFFF, 1'b1);
                3: program_regs(1'b1, 16'h0000, 1'b0);
                default: program_regs(1'($urandom_range(1)), pick_gain(),
                                      1'($urandom_range(1)));
            endcase
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 82; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 82; end
                default: begin idle_pct = 38; stall_pct <= 38; end
            endcase
            // early segments run without block ends so packets fill up
            case (seg < 3 ? 0 : $urandom_range(3))
                0, 1: block_end_pct = 0;
                2: block_end_pct = 2;
                default: block_end_pct = 15;
            endcase
            repeat (100) begin
                send_sample(pick_sample(), $urandom_range(7) == 0,
                            $urandom_range(99) < block_end_pct);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== pcm_decimate_gain_g711_encode_core.f =====
src/pdge_pkg.sv
src/pdge_encode.sv
src/pcm_decimate_gain_g711_encode_core.sv
tb/sv/g711_capture_monitor.sv
tb/sv/tb_top.sv
